// ----- rtl/occupancy_costmap_inflation_unit_assert.svh -----
// Assertion macros shared by the checker of the costmap inflation unit.
`ifndef OCCUPANCY_COSTMAP_INFLATION_UNIT_ASSERT_SVH
`define OCCUPANCY_COSTMAP_INFLATION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OCINF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ocinf check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OCINF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ocinf check failed");

`endif

// ----- rtl/ocinf_pkg.sv -----
// Shared types and constants of the costmap inflation unit.
package ocinf_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [7:0] OCC_OBSTACLE = 8'sd100;

  localparam logic [7:0] COST_FREE    = 8'd0;
  localparam logic [7:0] COST_PEN_MAX = 8'd254;
  localparam logic [7:0] COST_LETHAL  = 8'd255;

  localparam int COST_SCALE    = 15;
  localparam int COST_SCALE_SQ = 225;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_INFLATE    = 2'd2;
  localparam logic [1:0] REG_PENALTY    = 2'd3;

  localparam int CFG_W    = 9;
  localparam int DIM_W    = 9;
  localparam int RADIUS_W = 5;
  // signed coordinate: row/col plus or minus the reach
  localparam int COORD_W  = 11;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic wr_rd;
    logic wr_wb;
    logic scan_init;
    logic scan_step;
    logic sqrt_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic write_ok;
    logic off_map;
    logic scan_last;
    logic pipe_empty;
    logic sqrt_done;
  } status_t;

endpackage

// ----- rtl/ocinf_sqrt.sv -----
// Iterative ceiling square root, one root bit per cycle.
module ocinf_sqrt #(
  parameter int NW = 21
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            operand,
  output logic                     done,
  output logic [(NW+1)/2:0]        result
);

  localparam int RTW  = (NW + 1) / 2;
  localparam int NPAD = 2 * RTW;
  localparam int REMW = RTW + 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic [NPAD-1:0]   n_r;
  logic [REMW-1:0]   rem_r;
  logic [RTW-1:0]    root_r;
  logic [CNTW-1:0]   cnt_r;
  logic              run_r;
  logic              done_r;

  logic [REMW+1:0]   rem_sh;
  logic [REMW+1:0]   trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, n_r[NPAD-1:NPAD-2]};
    trial  = (REMW+2)'({root_r, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(RTW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= NPAD'(operand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      n_r <= {n_r[NPAD-3:0], 2'b00};
      if (fits) begin
        rem_r  <= REMW'(rem_sh - trial);
        root_r <= {root_r[RTW-2:0], 1'b1};
      end else begin
        rem_r  <= REMW'(rem_sh);
        root_r <= {root_r[RTW-2:0], 1'b0};
      end
    end
  end

  // round up when the remainder is not zero
  assign result = (RTW+1)'(root_r) + (RTW+1)'(rem_r != '0);
  assign done   = done_r;

endmodule

// ----- rtl/ocinf_datapath.sv -----
// Datapath: configuration, obstacle bitmap, row scan pipeline and cost math.
module ocinf_datapath #(
  parameter int GRID_DIM  = 256,
  parameter int MAX_REACH = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_op,
  input  logic [7:0]                    in_col,
  input  logic [7:0]                    in_row,
  input  logic signed [7:0]             in_occupancy,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ocinf_pkg::CFG_W-1:0]   cfg_wdata,
  input  ocinf_pkg::cmd_t               cmd,
  output ocinf_pkg::status_t            sts,
  output logic                          out_valid,
  output logic [7:0]                    out_cost,
  output logic                          out_in_map
);

  localparam int AW    = $clog2(GRID_DIM);
  localparam int RW    = $clog2(MAX_REACH + 1);
  localparam int WIN   = 2 * MAX_REACH + 1;
  localparam int EXTW  = GRID_DIM + 2 * MAX_REACH;
  localparam int D2W   = 2 * RW + 1;
  localparam int NW    = D2W + 8;
  localparam int RTW   = (NW + 1) / 2;
  localparam int FULLW = RW + 4;
  localparam int PW0   = (FULLW > RTW + 1) ? FULLW : RTW + 1;
  localparam int PW    = (PW0 > 9) ? PW0 : 9;
  localparam int CW    = ocinf_pkg::COORD_W;

  // configuration registers
  logic [ocinf_pkg::DIM_W-1:0]    map_width_r;
  logic [ocinf_pkg::DIM_W-1:0]    map_height_r;
  logic [ocinf_pkg::RADIUS_W-1:0] inflate_r;
  logic [ocinf_pkg::RADIUS_W-1:0] penalty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      inflate_r    <= 5'd8;
      penalty_r    <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ocinf_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        ocinf_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        ocinf_pkg::REG_INFLATE:    inflate_r    <= cfg_wdata[ocinf_pkg::RADIUS_W-1:0];
        ocinf_pkg::REG_PENALTY:    penalty_r    <= cfg_wdata[ocinf_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ocinf_pkg::DIM_W-1:0] w_eff;
  logic [ocinf_pkg::DIM_W-1:0] h_eff;
  logic [RW-1:0]               p_eff;

  always_comb begin
    w_eff = (32'(map_width_r) > GRID_DIM) ? ocinf_pkg::DIM_W'(GRID_DIM) : map_width_r;
    h_eff = (32'(map_height_r) > GRID_DIM) ? ocinf_pkg::DIM_W'(GRID_DIM) : map_height_r;
    p_eff = (32'(penalty_r) > MAX_REACH) ? RW'(MAX_REACH) : RW'(penalty_r);
  end

  // captured item
  logic                op_r;
  logic [7:0]          col_r;
  logic [7:0]          row_r;
  logic signed [7:0]   occ_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      col_r <= in_col;
      row_r <= in_row;
      occ_r <= in_occupancy;
    end
  end

  // obstacle bitmap, one grid row per word
  logic [GRID_DIM-1:0] grid_mem [GRID_DIM];
  logic [GRID_DIM-1:0] rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [GRID_DIM-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [GRID_DIM-1:0] wb_row;
  logic [AW-1:0]       clr_cnt_r;

  // scan position
  logic signed [RW:0]     dy_r;
  logic signed [CW-1:0]   oy;
  logic                   oy_ok;

  always_comb begin
    oy    = CW'($signed({1'b0, row_r})) + CW'(dy_r);
    oy_ok = (oy >= 0) && (oy < $signed(CW'({1'b0, h_eff})));
  end

  always_comb begin
    wb_row = rd_data_r;
    wb_row[AW'(col_r)] = (occ_r == ocinf_pkg::OCC_OBSTACLE);
  end

  always_comb begin
    mem_we    = cmd.clr_step || cmd.wr_wb;
    mem_waddr = cmd.clr_step ? clr_cnt_r : AW'(row_r);
    mem_wdata = cmd.clr_step ? '0 : wb_row;
    mem_re    = cmd.wr_rd || cmd.scan_step;
    mem_raddr = cmd.scan_step ? AW'(oy) : AW'(row_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // scan pipeline: read row, cut window segment, nearest column, distance
  logic                    s1_v_r, s2_v_r, s3_v_r;
  logic signed [RW:0]      s1_dy_r, s2_dy_r, s3_dy_r;
  logic [WIN-1:0]          seg_r;
  logic [RW-1:0]           s3_dx_r;
  logic                    found_r;
  logic [D2W-1:0]          min_d2_r;

  logic [EXTW-1:0]         ext_row;
  logic [EXTW-1:0]         ext_sh;
  logic [WIN-1:0]          seg_keep;
  logic [MAX_REACH:0]      near;
  logic                    hit;
  logic [RW-1:0]           dx_near;
  logic [RW-1:0]           dy_abs;
  logic [2*RW-1:0]         sq_x, sq_y;
  logic [D2W-1:0]          d2;

  always_comb begin
    ext_row = {{MAX_REACH{1'b0}}, rd_data_r, {MAX_REACH{1'b0}}};
    ext_sh  = ext_row >> col_r;
    for (int j = 0; j < WIN; j++) begin
      seg_keep[j] = ext_sh[j]
                    && (j + 32'(p_eff) >= MAX_REACH)
                    && (j <= MAX_REACH + 32'(p_eff))
                    && (32'(col_r) + j < 32'(w_eff) + MAX_REACH);
    end
  end

  always_comb begin
    near[0] = seg_r[MAX_REACH];
    for (int k = 1; k <= MAX_REACH; k++) begin
      near[k] = seg_r[MAX_REACH + k] || seg_r[MAX_REACH - k];
    end
    hit     = 1'b0;
    dx_near = '0;
    for (int k = MAX_REACH; k >= 0; k--) begin
      if (near[k]) begin
        hit     = 1'b1;
        dx_near = RW'(k);
      end
    end
  end

  always_comb begin
    dy_abs = s3_dy_r[RW] ? RW'(-s3_dy_r) : RW'(s3_dy_r);
    sq_x   = s3_dx_r * s3_dx_r;
    sq_y   = dy_abs * dy_abs;
    d2     = D2W'(sq_x) + D2W'(sq_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.scan_step && oy_ok;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      dy_r <= -$signed({1'b0, p_eff});
    end else if (cmd.scan_step && !sts.scan_last) begin
      dy_r <= dy_r + 1'b1;
    end
    s1_dy_r <= dy_r;
    s2_dy_r <= s1_dy_r;
    seg_r   <= seg_keep;
    s3_dy_r <= s2_dy_r;
    s3_dx_r <= dx_near;
  end

  // keep the nearest obstacle: the penalty falls as the distance grows
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      found_r  <= 1'b0;
      min_d2_r <= '1;
    end else if (s3_v_r && (!found_r || d2 < min_d2_r)) begin
      found_r  <= 1'b1;
      min_d2_r <= d2;
    end
  end

  // cost math
  logic [2*ocinf_pkg::RADIUS_W-1:0] i2;
  logic [2*RW-1:0]                  p2;
  logic                             lethal;
  logic                             pen_ok;
  logic [NW-1:0]                    sq_in;
  logic                             sqrt_done;
  logic [RTW:0]                     sqrt_res;
  logic [FULLW-1:0]                 full;
  logic [PW-1:0]                    pen;
  logic [7:0]                       pen_sat;
  logic [7:0]                       cost_nxt;

  always_comb begin
    i2     = inflate_r * inflate_r;
    p2     = p_eff * p_eff;
    lethal = found_r && (32'(min_d2_r) <= 32'(i2));
    pen_ok = found_r && (32'(min_d2_r) <= 32'(p2));
    sq_in  = NW'(min_d2_r) * NW'(ocinf_pkg::COST_SCALE_SQ);
    full   = FULLW'(p_eff) * FULLW'(ocinf_pkg::COST_SCALE);
    pen    = (PW'(full) >= PW'(sqrt_res)) ? PW'(full) - PW'(sqrt_res) : '0;
    pen_sat = (pen > PW'(ocinf_pkg::COST_PEN_MAX)) ? ocinf_pkg::COST_PEN_MAX : 8'(pen);
    if (lethal) begin
      cost_nxt = ocinf_pkg::COST_LETHAL;
    end else if (pen_ok) begin
      cost_nxt = pen_sat;
    end else begin
      cost_nxt = ocinf_pkg::COST_FREE;
    end
  end

  ocinf_sqrt #(
    .NW (NW)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (sq_in),
    .done    (sqrt_done),
    .result  (sqrt_res)
  );

  // result register
  logic       out_valid_r;
  logic [7:0] out_cost_r;
  logic       out_in_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_cost_r   <= sts.off_map ? ocinf_pkg::COST_FREE : cost_nxt;
      out_in_map_r <= !sts.off_map;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_cost   = out_cost_r;
  assign out_in_map = out_in_map_r;

  always_comb begin
    sts.clr_last   = (clr_cnt_r == AW'(GRID_DIM - 1));
    sts.is_query   = (op_r == ocinf_pkg::OP_QUERY);
    sts.write_ok   = (32'(col_r) < GRID_DIM) && (32'(row_r) < GRID_DIM);
    sts.off_map    = ({1'b0, col_r} >= w_eff) || ({1'b0, row_r} >= h_eff);
    sts.scan_last  = (dy_r == $signed({1'b0, p_eff}));
    sts.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;
    sts.sqrt_done  = sqrt_done;
  end

endmodule

// ----- rtl/ocinf_ctrl.sv -----
// Controller: sequences clearing, cell writes and cost queries.
module ocinf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output ocinf_pkg::cmd_t      cmd,
  input  ocinf_pkg::status_t   sts
);

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_DISPATCH = 9'b000000100,
    ST_WR_RD    = 9'b000001000,
    ST_WR_WB    = 9'b000010000,
    ST_SCAN     = 9'b000100000,
    ST_DRAIN    = 9'b001000000,
    ST_SQRT     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts.is_query) begin
          // drop writes that fall outside the stored grid
          state_nxt = sts.write_ok ? ST_WR_RD : ST_IDLE;
        end else if (sts.off_map) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_WR_RD: begin
        cmd.wr_rd = 1'b1;
        state_nxt = ST_WR_WB;
      end
      ST_WR_WB: begin
        cmd.wr_wb = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- rtl/occupancy_costmap_inflation_unit.sv -----
// Top level of the occupancy costmap inflation unit.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  -----------------------
//  input     in_op, in_col, in_row, in_occupancy          start & !busy
//  result    out_cost, out_in_map                         out_valid, one cycle
//  config    cfg_index, cfg_wdata                         cfg_we
//
// A write item reads its row, merges the bit and writes the row back; an off-map query goes to the result.
// A query dispatches, scans 2P+1 bitmap rows (one bitmap row per cycle), drains the row
// pipeline, runs the ceiling square root (10 root bits at the default reach limit),
// registers the cost and returns to idle, where the next item is taken.
// After reset a clearing pass zeroes the bitmap, one row a cycle, with busy high.
// Results cannot be held off; the next item may start as one shows.
module occupancy_costmap_inflation_unit #(
  parameter int GRID_DIM  = 256,
  parameter int MAX_REACH = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [7:0]                    in_col,
  input  logic [7:0]                    in_row,
  input  logic signed [7:0]             in_occupancy,
  output logic                          out_valid,
  output logic [7:0]                    out_cost,
  output logic                          out_in_map,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ocinf_pkg::CFG_W-1:0]   cfg_wdata
);

  ocinf_pkg::cmd_t    cmd;
  ocinf_pkg::status_t sts;

  ocinf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  ocinf_datapath #(
    .GRID_DIM  (GRID_DIM),
    .MAX_REACH (MAX_REACH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_occupancy (in_occupancy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_cost     (out_cost),
    .out_in_map   (out_in_map)
  );

endmodule

// ----- rtl/ocinf_checker.sv -----
// Port-level checker of the costmap inflation unit and its bind.
`include "occupancy_costmap_inflation_unit_assert.svh"

module ocinf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_cost,
  input logic       out_in_map
);

  // an accepted item shows busy in the cycle after it is taken
  `OCINF_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // results come one at a time
  `OCINF_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  // a result only shows once the item is finished
  `OCINF_ASSERT_IMP(a_result_idle, out_valid, !busy)
  // off-map queries report no cost
  `OCINF_ASSERT_IMP(a_off_map_free, out_valid && !out_in_map, out_cost == 8'd0)

endmodule

bind occupancy_costmap_inflation_unit ocinf_checker u_ocinf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_cost   (out_cost),
  .out_in_map (out_in_map)
);
